/* design/qebi_pkg.sv */
// types, register indexes and the encoder step table for the encoder and button front end
package qebi_pkg;

  typedef struct packed {
    logic        action;
    logic        level_a;
    logic        level_b;
    logic        button_level;
    logic [31:0] time_now;
  } in_item_t;

  typedef struct packed {
    logic signed [1:0] detent_step;
    logic              click;
    logic              long_press;
  } out_item_t;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_BUTTON_ACTIVE_LOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TIME     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS_TIME   = 2'd2;

  localparam logic        ACTION_SAMPLE = 1'b0;
  localparam logic        ACTION_POLL   = 1'b1;

  localparam logic        RST_BUTTON_ACTIVE_LOW = 1'b1;
  localparam logic [15:0] RST_DEBOUNCE_TIME     = 16'd50;
  localparam logic [15:0] RST_LONG_PRESS_TIME   = 16'd1000;
  localparam logic [1:0]  RST_PREVIOUS_AB       = 2'b11;

  localparam logic signed [7:0] DETENT_LIMIT = 8'sd3;
  localparam logic signed [1:0] STEP_UP      = 2'sb01;
  localparam logic signed [1:0] STEP_DOWN    = 2'sb11;
  localparam logic signed [1:0] STEP_NONE    = 2'sb00;

  // old ab in the upper two bits, new ab in the lower two
  function automatic logic signed [1:0] step_lookup(input logic [3:0] idx);
    logic signed [1:0] s;
    unique case (idx)
      4'd1, 4'd7, 4'd8, 4'd14: s = STEP_DOWN;
      4'd2, 4'd4, 4'd11, 4'd13: s = STEP_UP;
      default: s = STEP_NONE;
    endcase
    return s;
  endfunction

endpackage

/* design/quadrature_encoder_button_input.sv */
// top level of the rotary encoder and push-button front end
//
// in channel: one item per encoder pin sample (action 0, levels a and b) or per
// poll (action 1, raw button level and a wrapping millisecond timestamp).
// out channel: exactly one item for every input item, in order. a sample gives
// an all-zero item; a poll gives the pending detent (+1/-1, else 0) and a click
// or long press flag when a debounced release is seen.
// cfg channel: index 0 button_active_low, 1 debounce_time, 2 long_press_time;
// always ready; it is to be written only while the block is idle, which the block
// itself does not enforce. other indexes are dropped. an accepted item passes the
// input register, then the state update into the result register. throughput:
// one item per cycle while the receiver does not stall, set by the accumulator
// and button state update feeding back on itself.
// reset: synchronous, active low; clears the accumulator and button state,
// previous ab to 3 and loads the register defaults.
// a stalled receiver holds the result register; one more item waits in the
// input register, after which in_ready drops until the result is taken.
module quadrature_encoder_button_input (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_valid,
  output logic                                      in_ready,
  input  qebi_pkg::in_item_t                        in_data,
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output qebi_pkg::out_item_t                       out_data,
  input  logic                                      cfg_valid,
  output logic                                      cfg_ready,
  input  logic [qebi_pkg::CFG_IDX_W-1:0]            cfg_index,
  input  logic [qebi_pkg::CFG_DATA_W-1:0]           cfg_data
);

  logic               in_valid_r;
  qebi_pkg::in_item_t in_data_r;
  logic               out_valid_r;
  qebi_pkg::out_item_t out_data_r, out_data_nxt;

  logic        active_low_r;
  logic [15:0] debounce_r;
  logic [15:0] long_press_r;

  logic [1:0]        prev_ab_r, prev_ab_nxt;
  logic signed [7:0] acc_r, acc_nxt;
  logic              pressed_r, pressed_nxt;
  logic              handled_r, handled_nxt;
  logic [31:0]       press_start_r, press_start_nxt;
  logic [31:0]       last_release_r, last_release_nxt;

  logic              advance;
  logic [1:0]        cur_ab;
  logic signed [1:0] step;
  logic signed [8:0] sum;
  logic              pressed_now;
  logic [31:0]       since_release;
  logic [31:0]       held;
  logic              debounced;

  assign advance   = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  assign cur_ab        = {in_data_r.level_a, in_data_r.level_b};
  assign step          = qebi_pkg::step_lookup({prev_ab_r, cur_ab});
  assign sum           = {acc_r[7], acc_r} + {{7{step[1]}}, step};
  assign pressed_now   = in_data_r.button_level ^ active_low_r;
  assign since_release = in_data_r.time_now - last_release_r;
  assign held          = in_data_r.time_now - press_start_r;
  assign debounced     = since_release > {16'd0, debounce_r};

  always_comb begin
    prev_ab_nxt      = prev_ab_r;
    acc_nxt          = acc_r;
    pressed_nxt      = pressed_r;
    handled_nxt      = handled_r;
    press_start_nxt  = press_start_r;
    last_release_nxt = last_release_r;
    out_data_nxt     = '0;
    if (in_data_r.action == qebi_pkg::ACTION_SAMPLE) begin
      prev_ab_nxt = cur_ab;
      // saturate instead of wrapping at the 8-bit limits
      if (sum[8] != sum[7]) begin
        acc_nxt = sum[8] ? 8'sh80 : 8'sh7f;
      end else begin
        acc_nxt = sum[7:0];
      end
    end else begin
      if (acc_r > qebi_pkg::DETENT_LIMIT || acc_r < -qebi_pkg::DETENT_LIMIT) begin
        out_data_nxt.detent_step = acc_r[7] ? qebi_pkg::STEP_DOWN : qebi_pkg::STEP_UP;
        acc_nxt = '0;
      end
      if (pressed_now && !pressed_r) begin
        if (debounced) begin
          pressed_nxt     = 1'b1;
          press_start_nxt = in_data_r.time_now;
          handled_nxt     = 1'b0;
        end
      end else if (!pressed_now && pressed_r) begin
        if (debounced && !handled_r) begin
          if (held < {16'd0, long_press_r}) begin
            out_data_nxt.click = 1'b1;
          end else begin
            out_data_nxt.long_press = 1'b1;
          end
          handled_nxt = 1'b1;
        end
        pressed_nxt      = 1'b0;
        last_release_nxt = in_data_r.time_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      active_low_r   <= qebi_pkg::RST_BUTTON_ACTIVE_LOW;
      debounce_r     <= qebi_pkg::RST_DEBOUNCE_TIME;
      long_press_r   <= qebi_pkg::RST_LONG_PRESS_TIME;
      prev_ab_r      <= qebi_pkg::RST_PREVIOUS_AB;
      acc_r          <= '0;
      pressed_r      <= 1'b0;
      handled_r      <= 1'b0;
      press_start_r  <= '0;
      last_release_r <= '0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r    <= 1'b1;
        prev_ab_r      <= prev_ab_nxt;
        acc_r          <= acc_nxt;
        pressed_r      <= pressed_nxt;
        handled_r      <= handled_nxt;
        press_start_r  <= press_start_nxt;
        last_release_r <= last_release_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          qebi_pkg::CFG_BUTTON_ACTIVE_LOW: active_low_r <= cfg_data[0];
          qebi_pkg::CFG_DEBOUNCE_TIME:     debounce_r   <= cfg_data;
          qebi_pkg::CFG_LONG_PRESS_TIME:   long_press_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

/* design/qebi_checker.sv */
// port-level checks for the encoder and button front end, bound to the top level
module qebi_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input qebi_pkg::out_item_t out_data
);

  // a result waiting on the receiver stays put
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // the input only waits behind a result the receiver is holding
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |-> out_valid && !out_ready)
    else $error("input blocked with no stalled result");

  // a release is either a click or a long press, never both
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.click && out_data.long_press))
    else $error("click and long press together");

  // a detent is only ever one step
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.detent_step != 2'b10)
    else $error("detent step out of range");

endmodule

bind quadrature_encoder_button_input qebi_checker u_qebi_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

/* test/tb_quadrature_encoder_button_input.sv */
// testbench for the encoder and button front end, checked against a predictor
module tb_quadrature_encoder_button_input;

  localparam int ITEM_TARGET = 1550;
  localparam int CYCLE_LIMIT = 400000;
  localparam int IDLE_MAX    = 12;
  localparam int DRAIN_WAIT  = 4;

  localparam logic [qebi_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  // step for each {old ab, new ab}
  localparam int TRANSITION_STEP [16] = '{0, -1, 1, 0, 1, 0, 0, -1, -1, 0, 0, 1, 0, 1, -1, 0};
  // walk from ab 3 that takes every one of the 16 transitions once
  localparam logic [1:0] AB_WALK [16] = '{2'd3, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2, 2'd3,
                                          2'd1, 2'd3, 2'd2, 2'd0, 2'd2, 2'd1, 2'd0, 2'd3};

  logic                                clk;
  logic                                rst_n;
  logic                                in_valid;
  logic                                in_ready;
  qebi_pkg::in_item_t                  in_data;
  logic                                out_valid;
  logic                                out_ready;
  qebi_pkg::out_item_t                 out_data;
  logic                                cfg_valid;
  logic                                cfg_ready;
  logic [qebi_pkg::CFG_IDX_W-1:0]      cfg_index;
  logic [qebi_pkg::CFG_DATA_W-1:0]     cfg_data;

  // predictor copy of the settings and state
  logic                     active_low_setting;
  logic [15:0]              debounce_setting;
  logic [15:0]              long_press_setting;
  logic [1:0]               last_ab;
  logic signed [7:0]        step_sum;
  logic                     is_pressed;
  logic                     is_handled;
  logic [31:0]              press_at;
  logic [31:0]              release_at;

  qebi_pkg::out_item_t      pending_responses[$];
  qebi_pkg::out_item_t      expected_now;
  int                       error_count;
  int                       cycle_count;
  int                       items_sent;
  int                       stall_left;
  logic                     sender_no_gaps;
  logic                     receiver_no_stalls;

  // stimulus side view of the pins and the clock
  logic [1:0]               enc_ab;
  logic                     button_down;
  logic [31:0]              now_ms;

  quadrature_encoder_button_input DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** quadrature_encoder_button_input: FAILED **");
      $finish;
    end
  end

  function automatic qebi_pkg::out_item_t encoder_button_response(input qebi_pkg::in_item_t it);
    qebi_pkg::out_item_t r;
    int          total;
    logic        pressed_now;
    logic [31:0] since_release;
    logic [31:0] held_for;
    r = '0;
    if (it.action == qebi_pkg::ACTION_SAMPLE) begin
      total = int'(step_sum) + TRANSITION_STEP[{last_ab, it.level_a, it.level_b}];
      if (total > 127) total = 127;
      if (total < -128) total = -128;
      step_sum = total[7:0];
      last_ab = {it.level_a, it.level_b};
    end else begin
      if (step_sum > 8'sd3 || step_sum < -8'sd3) begin
        r.detent_step = (step_sum > 8'sd0) ? qebi_pkg::STEP_UP : qebi_pkg::STEP_DOWN;
        step_sum = '0;
      end
      pressed_now = it.button_level ^ active_low_setting;
      since_release = it.time_now - release_at;
      if (pressed_now && !is_pressed) begin
        if (since_release > {16'h0, debounce_setting}) begin
          is_pressed = 1'b1;
          press_at = it.time_now;
          is_handled = 1'b0;
        end
      end else if (!pressed_now && is_pressed) begin
        if (since_release > {16'h0, debounce_setting} && !is_handled) begin
          held_for = it.time_now - press_at;
          if (held_for < {16'h0, long_press_setting}) r.click = 1'b1;
          else r.long_press = 1'b1;
          is_handled = 1'b1;
        end
        is_pressed = 1'b0;
        release_at = it.time_now;
      end
    end
    return r;
  endfunction

  function automatic logic [1:0] turn(input logic [1:0] ab, input logic cw);
    case (ab)
      2'b11: return cw ? 2'b01 : 2'b10;
      2'b01: return cw ? 2'b00 : 2'b11;
      2'b00: return cw ? 2'b10 : 2'b01;
      default: return cw ? 2'b11 : 2'b00;
    endcase
  endfunction

  // quiet time before a press, mostly near the debounce edge
  function automatic logic [31:0] pick_quiet();
    logic [31:0] d;
    d = {16'h0, debounce_setting};
    case ($urandom_range(0, 7))
      0: return $urandom_range(0, d);
      6: return $urandom_range(0, 2 * d + 4);
      7: return $urandom;
      default: return d + $urandom_range(0, 3);
    endcase
  endfunction

  // hold time, mostly near the long press edge
  function automatic logic [31:0] pick_hold();
    logic [31:0] lp;
    lp = {16'h0, long_press_setting};
    case ($urandom_range(0, 3))
      0: return (lp == 0) ? 32'd0 : lp - 1;
      1: return lp;
      2: return lp + $urandom_range(1, 3);
      default: return $urandom_range(0, lp + 4);
    endcase
  endfunction

  function automatic logic [15:0] pick_setting();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(1, 40));
    endcase
  endfunction

  // result side: check every accepted result against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_responses.size() == 0) begin
        $error("result item with no item pending: %p", out_data);
        error_count++;
      end else begin
        expected_now = pending_responses.pop_front();
        if (out_data.detent_step !== expected_now.detent_step) begin
          $error("detent_step: expected %0d, got %0d",
                 expected_now.detent_step, out_data.detent_step);
          error_count++;
        end
        if (out_data.click !== expected_now.click) begin
          $error("click: expected %0d, got %0d", expected_now.click, out_data.click);
          error_count++;
        end
        if (out_data.long_press !== expected_now.long_press) begin
          $error("long_press: expected %0d, got %0d",
                 expected_now.long_press, out_data.long_press);
          error_count++;
        end
      end
      stall_left = receiver_no_stalls ? 0 : $urandom_range(0, IDLE_MAX);
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready = 1'b0;
      stall_left--;
    end else begin
      out_ready = rst_n;
    end
  end

  // called at a falling edge; leaves valid high so back-to-back items need no toggle
  task automatic send_item(input qebi_pkg::in_item_t it);
    int gap;
    gap = sender_no_gaps ? 0 : $urandom_range(0, IDLE_MAX);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data = it;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_responses.push_back(encoder_button_response(it));
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_pins(input logic [1:0] ab);
    qebi_pkg::in_item_t it;
    it.action = qebi_pkg::ACTION_SAMPLE;
    it.level_a = ab[1];
    it.level_b = ab[0];
    it.button_level = 1'($urandom_range(0, 1));
    it.time_now = $urandom;
    enc_ab = ab;
    send_item(it);
  endtask

  task automatic send_poll(input logic pressed, input logic [31:0] t);
    qebi_pkg::in_item_t it;
    it.action = qebi_pkg::ACTION_POLL;
    it.level_a = 1'($urandom_range(0, 1));
    it.level_b = 1'($urandom_range(0, 1));
    it.button_level = pressed ^ active_low_setting;
    it.time_now = t;
    now_ms = t;
    button_down = pressed;
    send_item(it);
  endtask

  task automatic wait_for_responses();
    in_valid = 1'b0;
    while (pending_responses.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_register(input logic [qebi_pkg::CFG_IDX_W-1:0] idx,
                                input logic [qebi_pkg::CFG_DATA_W-1:0] value);
    cfg_index = idx;
    cfg_data = value;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      qebi_pkg::CFG_BUTTON_ACTIVE_LOW: active_low_setting = value[0];
      qebi_pkg::CFG_DEBOUNCE_TIME:     debounce_setting = value;
      qebi_pkg::CFG_LONG_PRESS_TIME:   long_press_setting = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic apply_settings(input logic low, input logic [15:0] deb, input logic [15:0] lp);
    logic [15:0] junk;
    junk = 16'($urandom);
    // upper bits of the one-bit register carry noise
    write_register(qebi_pkg::CFG_BUTTON_ACTIVE_LOW, {junk[15:1], low});
    write_register(qebi_pkg::CFG_DEBOUNCE_TIME, deb);
    write_register(qebi_pkg::CFG_LONG_PRESS_TIME, lp);
  endtask

  task automatic test_encoder_transitions();
    for (int i = 0; i < 16; i++) send_pins(AB_WALK[i]);
    // four clockwise steps make one detent
    repeat (4) send_pins(turn(enc_ab, 1'b1));
    send_poll(1'b0, 32'd1);
  endtask

  task automatic test_button_timing();
    send_poll(1'b1, 32'd50);    // press exactly at the debounce edge is ignored
    send_poll(1'b1, 32'd51);
    send_poll(1'b0, 32'd1050);  // held one short of long press: click
    send_poll(1'b1, 32'd1080);  // press too soon after release
    send_poll(1'b1, 32'd1101);
    send_poll(1'b0, 32'd2101);  // held exactly long press time
    send_poll(1'b1, 32'd2152);
    send_poll(1'b0, 32'd2110);  // release inside the window: silent
  endtask

  task automatic run_episode();
    int                 kind;
    int                 n;
    logic               cw;
    logic [31:0]        hold;
    logic [31:0]        used;
    logic [31:0]        dt;
    qebi_pkg::in_item_t it;
    kind = $urandom_range(0, 49);
    if (kind < 20) begin
      cw = 1'($urandom_range(0, 1));
      n = $urandom_range(3, 12);
      repeat (n) begin
        if ($urandom_range(0, 7) == 0) begin
          case ($urandom_range(0, 2))
            0: send_pins(enc_ab);
            1: send_pins(turn(enc_ab, !cw));
            default: send_pins(enc_ab ^ 2'b11);  // skipped state
          endcase
        end else begin
          send_pins(turn(enc_ab, cw));
        end
      end
      send_poll(button_down, now_ms + $urandom_range(0, 3));
    end else if (kind < 38) begin
      if ($urandom_range(0, 2) == 0) begin
        send_poll(1'b1, now_ms + $urandom_range(0, 2));
        send_poll(1'b0, now_ms + $urandom_range(0, 2));
      end
      send_poll(1'b1, now_ms + pick_quiet());
      hold = pick_hold();
      used = '0;
      repeat ($urandom_range(0, 2)) begin
        dt = $urandom_range(0, hold - used);
        send_poll(1'b1, now_ms + dt);
        used += dt;
      end
      send_poll(1'b0, now_ms + (hold - used));
      if ($urandom_range(0, 2) == 0) begin
        send_poll(1'b1, now_ms + $urandom_range(0, 2));
        send_poll(1'b0, now_ms + $urandom_range(0, 2));
      end
    end else if (kind < 47) begin
      repeat ($urandom_range(1, 6)) begin
        it.action = 1'($urandom_range(0, 1));
        it.level_a = 1'($urandom_range(0, 1));
        it.level_b = 1'($urandom_range(0, 1));
        it.button_level = 1'($urandom_range(0, 1));
        it.time_now = $urandom;
        if (it.action == qebi_pkg::ACTION_POLL) begin
          now_ms = it.time_now;
          button_down = it.button_level ^ active_low_setting;
        end else begin
          enc_ab = {it.level_a, it.level_b};
        end
        send_item(it);
      end
    end else if (kind < 49) begin
      wait_for_responses();
      send_poll(button_down, now_ms + $urandom_range(0, 3));
    end else begin
      // long spin drives the accumulator into its limit
      cw = 1'($urandom_range(0, 1));
      repeat ($urandom_range(130, 160)) send_pins(turn(enc_ab, cw));
      send_poll(button_down, now_ms + 1);
    end
  endtask

  task automatic test_random_traffic();
    int start;
    int phase;
    start = items_sent;
    phase = 0;
    while (items_sent - start < ITEM_TARGET) begin
      wait_for_responses();
      case (phase)
        0: apply_settings(1'b0, 16'h0000, 16'h0000);
        1: apply_settings(1'b1, 16'hFFFF, 16'hFFFF);
        default: apply_settings(1'($urandom_range(0, 1)), pick_setting(), pick_setting());
      endcase
      if ($urandom_range(0, 3) == 0) write_register(CFG_UNUSED, 16'($urandom));
      sender_no_gaps = ($urandom_range(0, 3) == 0);
      receiver_no_stalls = ($urandom_range(0, 3) == 0);
      // timestamps wrap during this phase
      if (phase == 3) now_ms = 32'hFFFF_FFFF - $urandom_range(0, 200);
      repeat ($urandom_range(15, 30)) begin
        if (items_sent - start < ITEM_TARGET) run_episode();
      end
      phase++;
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    error_count = 0;
    cycle_count = 0;
    items_sent = 0;
    stall_left = 0;
    sender_no_gaps = 1'b0;
    receiver_no_stalls = 1'b0;
    enc_ab = 2'b11;
    button_down = 1'b0;
    now_ms = '0;
    active_low_setting = qebi_pkg::RST_BUTTON_ACTIVE_LOW;
    debounce_setting = qebi_pkg::RST_DEBOUNCE_TIME;
    long_press_setting = qebi_pkg::RST_LONG_PRESS_TIME;
    last_ab = qebi_pkg::RST_PREVIOUS_AB;
    step_sum = '0;
    is_pressed = 1'b0;
    is_handled = 1'b0;
    press_at = '0;
    release_at = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_encoder_transitions();
    test_button_timing();
    test_random_traffic();

    wait_for_responses();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("** quadrature_encoder_button_input: PASSED **");
    end else begin
      $display("** quadrature_encoder_button_input: FAILED **");
    end
    $finish;
  end

endmodule

/* files.f */
design/qebi_pkg.sv
design/quadrature_encoder_button_input.sv
design/qebi_checker.sv
test/tb_quadrature_encoder_button_input.sv
